@@ src/md4_pkg.sv @@
// Shared types, constants and round tables for the MD4 stream hash.
package md4_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K2 = 32'h5A827999;
    localparam logic [31:0] K3 = 32'h6ED9EBA1;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int TOTAL_WIDTH = 61;
    localparam int ROUNDS = 48;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } md4_in_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic        part_index;
        logic        last_part;
    } md4_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_item;   // latch request byte and end flag
        logic       put_byte;    // write request byte into the buffer
        logic       put_pad;     // write 0x80 at the current position
        logic       zero_word;   // clear word at zero_idx
        logic [3:0] zero_idx;
        logic       put_len;     // write bit length into words 14 and 15
        logic       start_comp;  // copy chain words into round registers
        logic       round_en;    // perform one round
        logic [5:0] round_idx;
        logic       fold;        // add round registers into chain words
        logic       reinit;      // reload initial values
    } md4_cmd_t;

    typedef struct packed {
        logic       is_end;
        logic       has_byte;
        logic [5:0] pos;          // byte position within the block
    } md4_stat_t;

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] i;
        i = r[3:0];
        if (r < 6'd16) begin
            return i;
        end else if (r < 6'd32) begin
            return {i[1:0], i[3:2]};
        end else begin
            return {i[0], i[1], i[2], i[3]};
        end
    endfunction

    function automatic logic [4:0] shift_amt(input logic [5:0] r);
        logic [1:0] j;
        j = r[1:0];
        if (r < 6'd16) begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd7;
                2'd2: return 5'd11;
                default: return 5'd19;
            endcase
        end else if (r < 6'd32) begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd5;
                2'd2: return 5'd9;
                default: return 5'd13;
            endcase
        end else begin
            case (j)
                2'd0: return 5'd3;
                2'd1: return 5'd9;
                2'd2: return 5'd11;
                default: return 5'd15;
            endcase
        end
    endfunction

endpackage

@@ src/md4_datapath.sv @@
// Datapath: block buffer, byte count, chain words and the shared round unit.
module md4_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  md4_pkg::md4_in_t  in_item,
    input  md4_pkg::md4_cmd_t cmd,
    output md4_pkg::md4_stat_t stat,
    output logic [127:0]      digest
);
    import md4_pkg::*;

    logic [31:0] buf_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] r_reg [4];
    logic [TOTAL_WIDTH-1:0] total_reg;
    logic [7:0] byte_reg;
    logic has_reg, end_reg;

    logic [5:0] pos;
    logic [63:0] bits;
    logic [1:0] a_sel;
    logic [31:0] va, vb, vc, vd, f, k, sum, rot;
    logic [4:0] sh;
    logic [31:0] cur_word, pad_word;

    assign pos = total_reg[5:0];
    assign bits = {total_reg, 3'b000};
    assign stat = '{is_end: end_reg, has_byte: has_reg, pos: pos};
    assign digest = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
    assign cur_word = buf_reg[pos[5:2]];

    // Round i updates register (4 - i) mod 4; the others follow in order.
    always_comb begin
        a_sel = 2'd0 - cmd.round_idx[1:0];
        va = r_reg[a_sel];
        vb = r_reg[a_sel + 2'd1];
        vc = r_reg[a_sel + 2'd2];
        vd = r_reg[a_sel + 2'd3];
        if (cmd.round_idx < 6'd16) begin
            f = (vb & vc) | (~vb & vd);
            k = '0;
        end else if (cmd.round_idx < 6'd32) begin
            f = (vb & vc) | (vb & vd) | (vc & vd);
            k = K2;
        end else begin
            f = vb ^ vc ^ vd;
            k = K3;
        end
        sum = va + f + buf_reg[msg_index(cmd.round_idx)] + k;
        sh = shift_amt(cmd.round_idx);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // The padding byte keeps the lower bytes of its word and clears the upper ones.
    always_comb begin
        case (pos[1:0])
            2'd0: pad_word = {24'h000000, PAD_BYTE};
            2'd1: pad_word = {16'h0000, PAD_BYTE, cur_word[7:0]};
            2'd2: pad_word = {8'h00, PAD_BYTE, cur_word[15:0]};
            default: pad_word = {PAD_BYTE, cur_word[23:0]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            byte_reg <= in_item.data_byte;
        end
        if (cmd.put_byte) begin
            buf_reg[pos[5:2]][pos[1:0]*8 +: 8] <= byte_reg;
        end
        if (cmd.put_pad) begin
            buf_reg[pos[5:2]] <= pad_word;
        end
        if (cmd.zero_word) begin
            buf_reg[cmd.zero_idx] <= '0;
        end
        if (cmd.put_len) begin
            buf_reg[14] <= bits[31:0];
            buf_reg[15] <= bits[63:32];
        end
        if (cmd.start_comp) begin
            for (int i = 0; i < 4; i++) begin
                r_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round_en) begin
            r_reg[a_sel] <= rot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
            total_reg <= '0;
            has_reg <= 1'b0;
            end_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                has_reg <= in_item.has_byte;
                end_reg <= in_item.end_of_message;
            end
            if (cmd.put_byte) begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.fold) begin
                for (int i = 0; i < 4; i++) begin
                    chain_reg[i] <= chain_reg[i] + r_reg[i];
                end
            end
        end
    end
endmodule

@@ src/md4_ctrl.sv @@
// Controller: sequences byte writes, padding, compression and digest output.
module md4_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_part,
    input  md4_pkg::md4_stat_t stat,
    output md4_pkg::md4_cmd_t  cmd
);
    import md4_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_ZERO  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic final_reg, final_next;   // compression is the last one of the message
    logic part_reg, part_next;
    logic [3:0] start_word;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_part = part_reg;
    // Words after the padding byte's word are cleared; after a spill all are.
    assign start_word = stat.pos[5:2] + 4'd1;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        final_next = final_reg;
        part_next = part_reg;
        cmd = '0;
        cmd.round_idx = cnt_reg;
        cmd.zero_idx = cnt_reg[3:0];
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = S_BYTE;
                end
            end
            S_BYTE: begin
                if (stat.has_byte) begin
                    cmd.put_byte = 1'b1;
                    if (stat.pos == 6'd63) begin
                        cmd.start_comp = 1'b1;
                        cnt_next = '0;
                        final_next = 1'b0;
                        state_next = S_ROUND;
                    end else if (stat.is_end) begin
                        state_next = S_PAD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (stat.is_end) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PAD: begin
                cmd.put_pad = 1'b1;
                cnt_next = {2'b00, start_word};
                final_next = (stat.pos < 6'd56);
                state_next = (stat.pos[5:2] == 4'd15) ? S_ZERO : S_ZERO;
                if (stat.pos[5:2] == 4'd15) begin
                    cnt_next = 6'd16;
                end
            end
            S_ZERO: begin
                // Clear one word per cycle up to the end of the block.
                if (cnt_reg < 6'd16) begin
                    cmd.zero_word = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                end else begin
                    if (final_reg) begin
                        cmd.put_len = 1'b1;
                    end
                    cmd.start_comp = 1'b1;
                    cnt_next = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ROUNDS - 1)) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
                if (!stat.is_end) begin
                    state_next = S_IDLE;
                end else if (stat.has_byte && stat.pos == 6'd0 && !final_reg
                             && cnt_reg == 6'(ROUNDS)) begin
                    // A full block just closed on the final byte: pad a new one.
                    final_next = 1'b1;
                    state_next = S_PAD;
                end else if (final_reg) begin
                    part_next = 1'b0;
                    state_next = S_OUT;
                end else begin
                    // Padding spilled: next block is all zeros plus length.
                    final_next = 1'b1;
                    cnt_next = '0;
                    state_next = S_ZERO;
                end
                if (stat.is_end && !final_reg && !stat.has_byte) begin
                    final_next = 1'b1;
                    cnt_next = '0;
                    state_next = S_ZERO;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    part_next = 1'b1;
                    if (part_reg) begin
                        cmd.reinit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            final_reg <= 1'b0;
            part_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            final_reg <= final_next;
            part_reg <= part_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input ready while result shown");
    a_round_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (cnt_reg < 6'(ROUNDS)))
        else $error("round counter out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(part_reg)))
        else $error("result dropped while stalled");
endmodule

@@ src/md4_hash_stream.sv @@
// Top level of the streaming MD4 hash.
// A plain byte is written to the buffer; a block-closing byte adds the 48 shared
// rounds and the chain fold, run by one round unit one round per cycle.
// The final request adds padding, one or two compressions, then two result
// requests. A new request is taken only once the previous one is done.
// Reset (aresetn low, synchronous) loads the MD4 initial values and clears the count.
module md4_hash_stream (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md4_pkg::md4_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md4_pkg::md4_out_t m_data
);
    import md4_pkg::*;

    md4_cmd_t cmd;
    md4_stat_t stat;
    logic [127:0] digest;
    logic part;

    md4_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_part(part), .stat(stat), .cmd(cmd)
    );

    md4_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .cmd(cmd),
        .stat(stat), .digest(digest)
    );

    assign m_data.digest_part = part ? digest[127:64] : digest[63:0];
    assign m_data.part_index = part;
    assign m_data.last_part = part;
endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the streaming MD4 hash: directed table, then random messages.
`timescale 1ns / 100ps

module tb;
    import md4_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    md4_in_t s_data;
    logic m_valid;
    logic m_ready;
    md4_out_t m_data;

    md4_hash_stream dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [60:0] total;
    md4_out_t digest_q [$];
    int errors;
    longint cycles;

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] r [4];
        logic [31:0] b, c, d, f, w, k;
        int a, idx, sh, p, j;
        for (int i = 0; i < 4; i++) r[i] = chain[i];
        for (int n = 0; n < 48; n++) begin
            p = n / 16;
            j = n % 16;
            a = (4 - j) & 3;
            b = r[(a + 1) & 3];
            c = r[(a + 2) & 3];
            d = r[(a + 3) & 3];
            if (p == 0) begin
                f = (b & c) | (~b & d);
                idx = j;
                k = 32'h0;
                sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 7 : (j % 4 == 2) ? 11 : 19;
            end else if (p == 1) begin
                f = (b & c) | (b & d) | (c & d);
                idx = (j % 4) * 4 + j / 4;
                k = K2;
                sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 5 : (j % 4 == 2) ? 9 : 13;
            end else begin
                f = b ^ c ^ d;
                idx = {j[0], j[1], j[2], j[3]};
                k = K3;
                sh = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 9 : (j % 4 == 2) ? 11 : 15;
            end
            w = blk[idx];
            r[a] = rol(r[a] + f + w + k, sh);
        end
        for (int i = 0; i < 4; i++) chain[i] += r[i];
    endtask

    task automatic store_byte(input int pos, input logic [7:0] v);
        blk[pos / 4][(pos % 4) * 8 +: 8] = v;
    endtask

    task automatic restart_hash();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        total = '0;
    endtask

    task automatic predict_digest(input md4_in_t req);
        int pos;
        logic [63:0] bits;
        md4_out_t res;
        if (req.has_byte) begin
            pos = total[5:0];
            store_byte(pos, req.data_byte);
            total = total + 1'b1;
            if (pos == 63) compress();
        end
        if (req.end_of_message) begin
            pos = total[5:0];
            store_byte(pos, PAD_BYTE);
            for (int i = pos + 1; i < 64; i++) store_byte(i, 8'h00);
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            bits = {total, 3'b000};
            blk[14] = bits[31:0];
            blk[15] = bits[63:32];
            compress();
            res.digest_part = {chain[1], chain[0]};
            res.part_index = 1'b0;
            res.last_part = 1'b0;
            digest_q.push_back(res);
            res.digest_part = {chain[3], chain[2]};
            res.part_index = 1'b1;
            res.last_part = 1'b1;
            digest_q.push_back(res);
            restart_hash();
        end
    endtask

    // Directed rows; golden values only for the empty message and "abc".
    typedef struct {
        md4_in_t req;
        logic has_gold;
        logic [63:0] gold_lo;
        logic [63:0] gold_hi;
    } row_t;
    row_t rows [$];

    task automatic add_row(input logic [7:0] db, input logic hb, input logic em,
                           input logic g = 1'b0, input logic [63:0] lo = '0,
                           input logic [63:0] hi = '0);
        row_t r;
        r.req = '{data_byte: db, has_byte: hb, end_of_message: em};
        r.has_gold = g;
        r.gold_lo = lo;
        r.gold_hi = hi;
        rows.push_back(r);
    endtask

    // Burst/gap pacing for the sender.
    int burst_left;

    task automatic send_request(input md4_in_t req);
        while (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 40);
            else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 40);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_digest(req);
    endtask

    // Receiver stall pattern: alternating ready runs and stall runs.
    int stall_cnt;
    logic stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cnt <= 3;
            stall_phase <= 1'b1;
        end else if (stall_cnt == 0) begin
            stall_phase <= ~stall_phase;
            m_ready <= stall_phase;
            stall_cnt <= stall_phase ? $urandom_range(0, 60) : $urandom_range(0, 8);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
    end

    always @(posedge aclk) begin
        md4_out_t exp;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest half %h", $time, m_data);
                errors++;
            end else begin
                exp = digest_q.pop_front();
                if (m_data.digest_part !== exp.digest_part) begin
                    $display("%0t: digest_part expected %h actual %h", $time,
                             exp.digest_part, m_data.digest_part);
                    errors++;
                end
                if (m_data.part_index !== exp.part_index) begin
                    $display("%0t: part_index expected %b actual %b", $time,
                             exp.part_index, m_data.part_index);
                    errors++;
                end
                if (m_data.last_part !== exp.last_part) begin
                    $display("%0t: last_part expected %b actual %b", $time,
                             exp.last_part, m_data.last_part);
                    errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        md4_in_t req;
        int len;
        int sent;
        md4_out_t lo_e, hi_e;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        restart_hash();
        for (int i = 0; i < 16; i++) blk[i] = '0;

        // Empty message, an idle item, "abc", byte and end together, extremes.
        add_row(8'hFF, 1'b0, 1'b1, 1'b1, 64'h31e96ad1e0cfd631, 64'hc089c0e0d7593cb7);
        add_row(8'h5A, 1'b0, 1'b0);
        add_row("a", 1'b1, 1'b0);
        add_row("b", 1'b1, 1'b0);
        add_row("c", 1'b1, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'h52d821af7a0148a4, 64'h9d72a67ae80ac15f);
        add_row(8'h00, 1'b1, 1'b1);
        add_row(8'hFF, 1'b1, 1'b1);
        add_row(8'hAA, 1'b1, 1'b0);
        add_row(8'h55, 1'b1, 1'b1);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].has_gold) begin
                send_request(rows[i].req);
                // The predictor just pushed this message's halves; check them too.
                lo_e = digest_q[digest_q.size() - 2];
                hi_e = digest_q[digest_q.size() - 1];
                if (lo_e.digest_part !== rows[i].gold_lo || hi_e.digest_part !== rows[i].gold_hi) begin
                    $display("%0t: known digest expected %h%h actual %h%h", $time,
                             rows[i].gold_lo, rows[i].gold_hi,
                             lo_e.digest_part, hi_e.digest_part);
                    errors++;
                end
            end else begin
                send_request(rows[i].req);
            end
        end

        // Random messages, lengths clustered around block and padding boundaries.
        sent = 0;
        while (sent < 1250) begin
            case ($urandom_range(0, 4))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(52, 70);
                2: len = $urandom_range(115, 130);
                default: len = $urandom_range(0, 140);
            endcase
            for (int i = 0; i < len; i++) begin
                req.data_byte = 8'($urandom_range(0, 255));
                req.has_byte = 1'b1;
                req.end_of_message = (i == len - 1) && $urandom_range(0, 1);
                if ($urandom_range(0, 15) == 0) begin
                    send_request('{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                                   end_of_message: 1'b0});
                end
                send_request(req);
                sent++;
                if (req.end_of_message) break;
            end
            if (!req.end_of_message || len == 0) begin
                req.data_byte = 8'($urandom_range(0, 255));
                req.has_byte = 1'b0;
                req.end_of_message = 1'b1;
                send_request(req);
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
